### hw/rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
`timescale 1ns / 1ps

package pps_pkg;

   localparam int IdWidth       = 8;
   localparam int BurstWidth    = 16;
   localparam int PriorityWidth = 8;

   localparam logic FuncArrival = 1'b0;
   localparam logic FuncTick    = 1'b1;

   // One request transaction: an arrival or a tick
   typedef struct packed {
      logic                     func;
      logic [IdWidth-1:0]       job_id;
      logic [BurstWidth-1:0]    burst;
      logic [PriorityWidth-1:0] priority_req;
   } req_type;

   // One response transaction, produced by each tick
   typedef struct packed {
      logic [IdWidth-1:0] running_id;
      logic               pending;
      logic               overflow;
   } rsp_type;

   // A job as held in the queue and in the running slot
   typedef struct packed {
      logic [IdWidth-1:0]       id;
      logic [BurstWidth-1:0]    remaining;
      logic [PriorityWidth-1:0] pr;
   } job_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic arrive;
      logic countdown;
      logic dispatch;
      logic preempt;
      logic requeue;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic nonempty;
      logic run_valid;
      logic head_higher;
   } status_type;

endpackage

### hw/rtl/pps_ctrl.sv
// Controller state machine that sequences arrivals and ticks.
`timescale 1ns / 1ps

module pps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   func,
   input  pps_pkg::status_type    status,
   output pps_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import pps_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_DECIDE  = 2'd1;
   localparam logic [1:0] S_REQUEUE = 2'd2;
   localparam logic [1:0] S_RESP    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Decode state and status into commands and the next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (func == FuncTick) begin
                  cmd.countdown = 1'b1;
                  state_in      = S_DECIDE;
               end else begin
                  cmd.arrive = 1'b1;
               end
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (status.nonempty && !status.run_valid) begin
               cmd.dispatch = 1'b1;
            end else if (status.nonempty && status.head_higher) begin
               cmd.preempt = 1'b1;
               state_in    = S_REQUEUE;
            end
         end
         S_REQUEUE: begin
            cmd.requeue = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

### hw/rtl/pps_datapath.sv
// Datapath: sorted cell chain of waiting jobs, running slot and flags.
`timescale 1ns / 1ps

module pps_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pps_pkg::req_type       req_data,
   input  pps_pkg::cmd_type       cmd,
   output pps_pkg::status_type    status,
   output pps_pkg::rsp_type       rsp_data
);
   import pps_pkg::*;

   job_type                cell_ff  [QUEUE_DEPTH];
   job_type                cell_in  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff;
   logic [QUEUE_DEPTH-1:0] valid_in;
   logic [QUEUE_DEPTH-1:0] go;

   job_type run_ff;
   job_type run_in;
   logic    run_valid_ff;
   logic    run_valid_in;
   job_type spare_ff;
   logic    overflow_ff;
   logic    overflow_in;

   job_type ins_job;
   logic    full;
   logic    arrival_live;
   logic    ins_en;
   logic    pop_en;

   // Pick what to insert: the arriving job or the preempted one
   always_comb begin
      if (cmd.requeue) begin
         ins_job = spare_ff;
      end else begin
         ins_job.id        = req_data.job_id;
         ins_job.remaining = req_data.burst;
         ins_job.pr        = req_data.priority_req;
      end
   end

   assign full         = valid_ff[QUEUE_DEPTH-1];
   assign arrival_live = cmd.arrive && (req_data.burst != '0);
   assign ins_en       = cmd.requeue || (arrival_live && !full);
   assign pop_en       = cmd.dispatch || cmd.preempt;

   // Mark cells at or behind the insertion point (monotone along the chain)
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         go[i] = !valid_ff[i] || (cell_ff[i].pr < ins_job.pr);
      end
   end

   // Shift the chain: pop towards the head or open a slot for an insert
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_in[i]  = cell_ff[i];
         valid_in[i] = valid_ff[i];
      end
      if (pop_en) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            cell_in[i]  = cell_ff[i+1];
            valid_in[i] = valid_ff[i+1];
         end
         valid_in[QUEUE_DEPTH-1] = 1'b0;
      end else if (ins_en) begin
         if (go[0]) begin
            cell_in[0]  = ins_job;
            valid_in[0] = 1'b1;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (go[i-1]) begin
               cell_in[i]  = cell_ff[i-1];
               valid_in[i] = valid_ff[i-1];
            end else if (go[i]) begin
               cell_in[i]  = ins_job;
               valid_in[i] = 1'b1;
            end
         end
      end
   end

   // Count down, retire or replace the running job
   always_comb begin
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      if (cmd.countdown && run_valid_ff) begin
         run_in.remaining = run_ff.remaining - 1'b1;
         if (run_ff.remaining == BurstWidth'(1)) begin
            run_valid_in = 1'b0;
            run_in       = '0;
         end
      end
      if (pop_en) begin
         run_in       = cell_ff[0];
         run_valid_in = 1'b1;
      end
   end

   // Latch the sticky overflow on a dropped arrival
   assign overflow_in = overflow_ff || (arrival_live && full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         run_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         run_valid_ff <= run_valid_in;
         overflow_ff  <= overflow_in;
      end
   end

   // Hold payload without reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      run_ff <= run_in;
      if (cmd.preempt) begin
         spare_ff <= run_ff;
      end
   end

   assign status.nonempty    = valid_ff[0];
   assign status.run_valid   = run_valid_ff;
   assign status.head_higher = valid_ff[0] && (cell_ff[0].pr > run_ff.pr);

   assign rsp_data.running_id = run_valid_ff ? run_ff.id : '0;
   assign rsp_data.pending    = valid_ff[0];
   assign rsp_data.overflow   = overflow_ff;

endmodule

### hw/rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler.
//
// Request channel: a transaction is taken at a rising edge with start high
// and busy low. req_data.func selects an arrival (queue a job) or a tick.
// busy stays low during an arrival, so arrivals may follow back to back.
// A burst of zero is ignored; an arrival to a full queue is dropped and
// sets the sticky overflow flag.
// A tick counts down the running job at the edge that takes it; busy then
// stays high while the controller steps through its states: the decide
// state dispatches the head to an idle slot or pops it to preempt a
// lower-priority running job, a preemption adds a requeue state to
// reinsert the preempted job into the sorted cell chain, and the response
// state presents the response. A new transaction is taken only once busy
// has fallen again after the response.
// Response channel: rsp_strobe is high for exactly one cycle per tick with
// rsp_data valid in that cycle; the receiver cannot stall it. Arrivals give
// no response.
// Reset (synchronous, active high) empties the queue, idles the running
// slot and clears the overflow flag.
`timescale 1ns / 1ps

module preemptive_priority_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pps_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output pps_pkg::rsp_type  rsp_data
);
   import pps_pkg::*;

   cmd_type    cmd;
   status_type status;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_data.func),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pps_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### hw/rtl/pps_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps

module pps_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input pps_pkg::req_type  req_data,
   input logic              rsp_strobe
);
   import pps_pkg::*;

   // A response appears only while a tick is in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while not busy");

   // A response ends the tick
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("response not followed by idle");

   // An accepted arrival gives no response and keeps the block free
   a_arrival_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == FuncArrival) |=> !rsp_strobe && !busy)
      else $error("arrival produced a response or raised busy");

   // An accepted tick raises busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == FuncTick) |=> busy && !rsp_strobe)
      else $error("tick not held busy");

endmodule

bind preemptive_priority_scheduler pps_port_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe)
);
